### hdl/spsc_pkg.sv
`timescale 1ns / 1ps
package spsc_pkg;

  localparam int PERIOD_WIDTH = 24;

  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 24;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;
  localparam int MUL_CNT_W = $clog2(MUL_B_W);

  localparam int DIV_N_W = 52;
  localparam int DIV_D_W = 37;
  localparam int DIV_CNT_W = $clog2(DIV_N_W);

  localparam int CFG_W = 24;
  localparam int CFG_IDX_W = 3;

  localparam longint unsigned K_POS     = 64'd5760;
  localparam longint unsigned K_MEGA    = 64'd1000000;
  localparam longint unsigned K_PER_NUM = 64'd5760000000;
  localparam longint unsigned RATE_MAX  = 64'd549755813887;
  localparam longint unsigned PER_MIN   = 64'd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P      = 3'd0,
    CFG_GAIN_I      = 3'd1,
    CFG_GAIN_D      = 3'd2,
    CFG_STEPS       = 3'd3,
    CFG_DIR_INVERT  = 3'd4,
    CFG_DEADBAND    = 3'd5,
    CFG_SLEW        = 3'd6,
    CFG_SPEED_LIMIT = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_TARGET   = 2'd0,
    ACT_POSITION = 2'd1,
    ACT_TICK     = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_POS_MUL,
    ST_POS_DIV,
    ST_INT_MUL,
    ST_P_MUL,
    ST_I_MUL,
    ST_I_DIV,
    ST_DR_MUL,
    ST_DR_DIV,
    ST_D_MUL,
    ST_SUM,
    ST_PER_MUL,
    ST_PER_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic               start;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [MUL_P_W-1:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic               start;
    logic [DIV_N_W-1:0] n;
    logic [DIV_D_W-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [DIV_N_W-1:0] q;
  } div_rsp_t;

  function automatic logic [2:0] ms_pins(input logic [2:0] code);
    logic [2:0] pins;
    case (code)
      3'd4:    pins = 3'b111;
      3'd3:    pins = 3'b011;
      3'd2:    pins = 3'b010;
      3'd1:    pins = 3'b001;
      default: pins = 3'b000;
    endcase
    return pins;
  endfunction

endpackage

### hdl/spsc_in_if.sv
`timescale 1ns / 1ps
interface spsc_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  action;
  logic signed [23:0] target_position;
  logic signed [23:0] meas_steps;
  logic        [19:0] elapsed_us;

  modport source(output valid, action, target_position, meas_steps, elapsed_us,
                 input ready);
  modport sink(input valid, action, target_position, meas_steps, elapsed_us,
               output ready);
endinterface

### hdl/spsc_out_if.sv
`timescale 1ns / 1ps
interface spsc_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] speed;
  logic               direction_pin;
  logic        [2:0]  ratio_code;
  logic        [2:0]  microstep_pins;
  logic        [spsc_pkg::PERIOD_WIDTH-1:0] timer_period_us;

  modport source(output valid, speed, direction_pin, ratio_code, microstep_pins,
                 timer_period_us, input ready);
  modport sink(input valid, speed, direction_pin, ratio_code, microstep_pins,
               timer_period_us, output ready);
endinterface

### hdl/stepper_pid_speed_controller_unit.sv
`timescale 1ns / 1ps
// Set target is stored at acceptance; set position runs one multiply and one
//   divide; a control tick runs a chain of them (no period multiply and divide
//   at zero speed), on one bit-serial multiplier and one restoring divider.
// Throughput: one transaction at a time; the next is taken once back in idle,
//   while a finished result may still wait in the output register.
// Reset: asynchronous, active low; registers to defaults, PID state to zero.
module stepper_pid_speed_controller_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [spsc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [spsc_pkg::CFG_W-1:0]      cfg_data_i,
  spsc_in_if.sink                         in_i,
  spsc_out_if.source                      out_o
);

  localparam int PW = spsc_pkg::PERIOD_WIDTH;
  localparam logic [PW-1:0] PER_TOP = {PW{1'b1}};

  // configuration
  logic [23:0] gain_p_q, gain_i_q, gain_d_q;
  logic [15:0] spr_q, deadband_q, slew_q, lim_q;
  logic        dir_inv_q;
  logic [15:0] spr_eff;

  // persistent controller state
  logic signed [23:0] tgt_q;
  logic signed [31:0] meas_q;
  logic signed [47:0] integ_q;
  logic signed [31:0] prev_q;
  logic signed [17:0] last_q;

  // per-transaction working registers
  logic signed [23:0] pos_q;
  logic signed [31:0] e_q;
  logic        [19:0] dt_q;
  logic signed [36:0] pt_q;
  logic signed [33:0] it_q;
  logic        [38:0] rate_q;
  logic signed [44:0] dterm_q;
  logic signed [16:0] v_q;
  logic        [15:0] av_q;
  logic        [2:0]  code_q;
  logic        [36:0] den_q;
  logic        [PW-1:0] per_q;

  // output slot
  logic               ovalid_q;
  logic signed [16:0] o_speed_q;
  logic               o_dir_q;
  logic        [2:0]  o_code_q;
  logic        [PW-1:0] o_per_q;

  spsc_pkg::state_e   state_q, state_d;
  logic               go_q;
  spsc_pkg::mul_req_t mul_req;
  spsc_pkg::mul_rsp_t mul_rsp;
  spsc_pkg::div_req_t div_req;
  spsc_pkg::div_rsp_t div_rsp;

  logic in_acc, out_free, is_mul, is_div;

  spsc_mul u_mul (.clk_i, .rst_ni, .req_i(mul_req), .rsp_o(mul_rsp));
  spsc_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  assign spr_eff  = (spr_q == 16'd0) ? 16'd1 : spr_q;
  assign in_acc   = in_i.valid && in_i.ready;
  assign out_free = !ovalid_q || out_o.ready;

  // error with saturation and deadband, formed as the tick is taken
  logic signed [32:0] diff;
  logic signed [31:0] e_sat, e_new;
  logic        [31:0] e_sat_mag, e_mag;
  logic signed [32:0] de;
  logic        [32:0] de_mag;
  logic        [47:0] integ_mag;
  logic        [23:0] pos_mag;

  always_comb begin
    diff = {{9{tgt_q[23]}}, tgt_q} - {meas_q[31], meas_q};
    if (diff > 33'sd2147483647)       e_sat = 32'h7fffffff;
    else if (diff < -33'sd2147483648) e_sat = 32'h80000000;
    else                              e_sat = diff[31:0];
    e_sat_mag = e_sat[31] ? 32'(-e_sat) : e_sat;
    e_new     = (e_sat_mag < {16'd0, deadband_q}) ? '0 : e_sat;
    e_mag     = e_q[31] ? 32'(-e_q) : e_q;
    de        = {e_q[31], e_q} - {prev_q[31], prev_q};
    de_mag    = de[32] ? 33'(-de) : de;
    integ_mag = integ_q[47] ? 48'(-integ_q) : integ_q;
    pos_mag   = pos_q[23] ? 24'(-pos_q) : pos_q;
  end

  // measured angle from quotient, saturated to 32 bits
  logic [51:0]        qv;
  logic signed [31:0] meas_new;
  always_comb begin
    qv = div_rsp.q;
    if (pos_q[23]) begin
      meas_new = (qv > 52'd2147483648) ? 32'h80000000 : 32'(-qv[31:0]);
    end else begin
      meas_new = (qv > 52'd2147483647) ? 32'h7fffffff : qv[31:0];
    end
  end

  // integral accumulate, saturated to 48 bits
  logic signed [52:0] eterm;
  logic signed [53:0] isum;
  logic signed [47:0] integ_new;
  always_comb begin
    eterm = e_q[31] ? 53'(-{1'b0, mul_rsp.prod[51:0]}) : {1'b0, mul_rsp.prod[51:0]};
    isum  = {{6{integ_q[47]}}, integ_q} + {eterm[52], eterm};
    if (isum > 54'sd140737488355327)       integ_new = 48'h7fffffffffff;
    else if (isum < -54'sd140737488355328) integ_new = 48'h800000000000;
    else                                   integ_new = isum[47:0];
  end

  // PID sum, slew limit, speed limit, ratio band
  logic signed [46:0] vsum;
  logic signed [18:0] slew_hi, slew_lo, v_slew;
  logic signed [16:0] v_lim;
  logic               hit_slew, hit_lim;
  logic        [15:0] av;
  logic        [2:0]  code;
  always_comb begin
    vsum = {{10{pt_q[36]}}, pt_q} + {{13{it_q[33]}}, it_q} + {{2{dterm_q[44]}}, dterm_q};
    slew_hi = {last_q[17], last_q} + {3'd0, slew_q};
    slew_lo = {last_q[17], last_q} - {3'd0, slew_q};
    hit_slew = 1'b1;
    if (vsum > $signed({{28{slew_hi[18]}}, slew_hi}))      v_slew = slew_hi;
    else if (vsum < $signed({{28{slew_lo[18]}}, slew_lo})) v_slew = slew_lo;
    else begin
      v_slew   = vsum[18:0];
      hit_slew = 1'b0;
    end
    hit_lim = 1'b1;
    if (v_slew > $signed({3'd0, lim_q}))          v_lim = {1'b0, lim_q};
    else if (v_slew < -$signed({3'd0, lim_q}))    v_lim = 17'(-{1'b0, lim_q});
    else begin
      v_lim   = v_slew[16:0];
      hit_lim = 1'b0;
    end
    av = v_lim[16] ? 16'(-v_lim) : v_lim[15:0];
    if (av < 16'd720)       code = 3'd4;
    else if (av < 16'd1440) code = 3'd3;
    else if (av < 16'd2880) code = 3'd2;
    else if (av < 16'd5760) code = 3'd1;
    else                    code = 3'd0;
  end

  // step period clamp
  logic [PW-1:0] per_new;
  always_comb begin
    if (div_rsp.q < 52'(spsc_pkg::PER_MIN))  per_new = PW'(spsc_pkg::PER_MIN);
    else if (div_rsp.q > 52'(PER_TOP))       per_new = PER_TOP;
    else                                     per_new = div_rsp.q[PW-1:0];
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      spsc_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_i.action)
            spsc_pkg::ACT_POSITION: state_d = spsc_pkg::ST_POS_MUL;
            spsc_pkg::ACT_TICK:     state_d = spsc_pkg::ST_INT_MUL;
            default:                state_d = spsc_pkg::ST_IDLE;
          endcase
        end
      end
      spsc_pkg::ST_POS_MUL: if (mul_rsp.done) state_d = spsc_pkg::ST_POS_DIV;
      spsc_pkg::ST_POS_DIV: if (div_rsp.done) state_d = spsc_pkg::ST_IDLE;
      spsc_pkg::ST_INT_MUL: if (mul_rsp.done) state_d = spsc_pkg::ST_P_MUL;
      spsc_pkg::ST_P_MUL:   if (mul_rsp.done) state_d = spsc_pkg::ST_I_MUL;
      spsc_pkg::ST_I_MUL:   if (mul_rsp.done) state_d = spsc_pkg::ST_I_DIV;
      spsc_pkg::ST_I_DIV:   if (div_rsp.done) state_d = spsc_pkg::ST_DR_MUL;
      spsc_pkg::ST_DR_MUL:  if (mul_rsp.done) state_d = spsc_pkg::ST_DR_DIV;
      spsc_pkg::ST_DR_DIV:  if (div_rsp.done) state_d = spsc_pkg::ST_D_MUL;
      spsc_pkg::ST_D_MUL:   if (mul_rsp.done) state_d = spsc_pkg::ST_SUM;
      spsc_pkg::ST_SUM:     state_d = (av == 16'd0) ? spsc_pkg::ST_OUT : spsc_pkg::ST_PER_MUL;
      spsc_pkg::ST_PER_MUL: if (mul_rsp.done) state_d = spsc_pkg::ST_PER_DIV;
      spsc_pkg::ST_PER_DIV: if (div_rsp.done) state_d = spsc_pkg::ST_OUT;
      spsc_pkg::ST_OUT:     if (out_free) state_d = spsc_pkg::ST_IDLE;
      default:              state_d = spsc_pkg::ST_IDLE;
    endcase
  end

  // unit operand select and launch
  always_comb begin
    is_mul    = 1'b0;
    is_div    = 1'b0;
    mul_req.a = '0;
    mul_req.b = '0;
    div_req.n = '0;
    div_req.d = '0;
    unique case (state_q)
      spsc_pkg::ST_POS_MUL: begin
        is_mul = 1'b1; mul_req.a = {24'd0, pos_mag}; mul_req.b = 24'(spsc_pkg::K_POS);
      end
      spsc_pkg::ST_POS_DIV: begin
        is_div = 1'b1; div_req.n = mul_rsp.prod[51:0]; div_req.d = {21'd0, spr_eff};
      end
      spsc_pkg::ST_INT_MUL: begin
        is_mul = 1'b1; mul_req.a = {16'd0, e_mag}; mul_req.b = {4'd0, dt_q};
      end
      spsc_pkg::ST_P_MUL: begin
        is_mul = 1'b1; mul_req.a = {16'd0, e_mag}; mul_req.b = gain_p_q;
      end
      spsc_pkg::ST_I_MUL: begin
        is_mul = 1'b1; mul_req.a = integ_mag; mul_req.b = gain_i_q;
      end
      spsc_pkg::ST_I_DIV: begin
        is_div = 1'b1; div_req.n = mul_rsp.prod[71:20]; div_req.d = 37'(spsc_pkg::K_MEGA);
      end
      spsc_pkg::ST_DR_MUL: begin
        is_mul = 1'b1; mul_req.a = {15'd0, de_mag}; mul_req.b = 24'(spsc_pkg::K_MEGA);
      end
      spsc_pkg::ST_DR_DIV: begin
        is_div = 1'b1; div_req.n = mul_rsp.prod[51:0]; div_req.d = {17'd0, dt_q};
      end
      spsc_pkg::ST_D_MUL: begin
        is_mul = 1'b1; mul_req.a = {9'd0, rate_q}; mul_req.b = gain_d_q;
      end
      spsc_pkg::ST_PER_MUL: begin
        is_mul = 1'b1; mul_req.a = {32'd0, av_q}; mul_req.b = {8'd0, spr_eff};
      end
      spsc_pkg::ST_PER_DIV: begin
        is_div = 1'b1; div_req.n = 52'(spsc_pkg::K_PER_NUM); div_req.d = den_q;
      end
      default: ;
    endcase
    mul_req.start = is_mul && !go_q;
    div_req.start = is_div && !go_q;
  end

  assign in_i.ready = (state_q == spsc_pkg::ST_IDLE);

  // control, configuration and controller state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= spsc_pkg::ST_IDLE;
      go_q      <= 1'b0;
      ovalid_q  <= 1'b0;
      gain_p_q  <= 24'd425984;
      gain_i_q  <= 24'd32768;
      gain_d_q  <= 24'd655;
      spr_q     <= 16'd200;
      dir_inv_q <= 1'b0;
      deadband_q <= 16'd128;
      slew_q    <= 16'd8000;
      lim_q     <= 16'd57600;
      tgt_q     <= '0;
      meas_q    <= '0;
      integ_q   <= '0;
      prev_q    <= '0;
      last_q    <= '0;
    end else begin
      state_q <= state_d;
      if (mul_req.start || div_req.start) go_q <= 1'b1;
      else if (mul_rsp.done || div_rsp.done) go_q <= 1'b0;

      if (ovalid_q && out_o.ready) ovalid_q <= 1'b0;
      if (state_q == spsc_pkg::ST_OUT && out_free) ovalid_q <= 1'b1;

      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          spsc_pkg::CFG_GAIN_P:      gain_p_q   <= cfg_data_i;
          spsc_pkg::CFG_GAIN_I:      gain_i_q   <= cfg_data_i;
          spsc_pkg::CFG_GAIN_D:      gain_d_q   <= cfg_data_i;
          spsc_pkg::CFG_STEPS:       spr_q      <= cfg_data_i[15:0];
          spsc_pkg::CFG_DIR_INVERT:  dir_inv_q  <= cfg_data_i[0];
          spsc_pkg::CFG_DEADBAND:    deadband_q <= cfg_data_i[15:0];
          spsc_pkg::CFG_SLEW:        slew_q     <= cfg_data_i[15:0];
          spsc_pkg::CFG_SPEED_LIMIT: lim_q      <= cfg_data_i[15:0];
          default: ;
        endcase
      end

      unique case (state_q)
        spsc_pkg::ST_IDLE: begin
          if (in_acc && in_i.action == spsc_pkg::ACT_TARGET) begin
            tgt_q   <= in_i.target_position;
            integ_q <= '0;
          end
        end
        spsc_pkg::ST_POS_DIV: if (div_rsp.done) meas_q <= meas_new;
        spsc_pkg::ST_INT_MUL: if (mul_rsp.done) integ_q <= integ_new;
        spsc_pkg::ST_D_MUL:   if (mul_rsp.done) prev_q <= e_q;
        spsc_pkg::ST_SUM: begin
          last_q <= {v_lim[16], v_lim};
          if (hit_slew || hit_lim) integ_q <= '0;
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      spsc_pkg::ST_IDLE: begin
        if (in_acc) begin
          pos_q <= in_i.meas_steps;
          e_q   <= e_new;
          dt_q  <= (in_i.elapsed_us == 20'd0) ? 20'd1 : in_i.elapsed_us;
        end
      end
      spsc_pkg::ST_P_MUL:
        if (mul_rsp.done) begin
          pt_q <= e_q[31] ? 37'(-{1'b0, mul_rsp.prod[55:20]}) : {1'b0, mul_rsp.prod[55:20]};
        end
      spsc_pkg::ST_I_DIV:
        if (div_rsp.done) begin
          it_q <= integ_q[47] ? 34'(-{1'b0, div_rsp.q[32:0]}) : {1'b0, div_rsp.q[32:0]};
        end
      spsc_pkg::ST_DR_DIV:
        if (div_rsp.done) begin
          rate_q <= (div_rsp.q > 52'(spsc_pkg::RATE_MAX)) ? 39'(spsc_pkg::RATE_MAX)
                                                          : div_rsp.q[38:0];
        end
      spsc_pkg::ST_D_MUL:
        if (mul_rsp.done) begin
          dterm_q <= de[32] ? 45'(-{1'b0, mul_rsp.prod[63:20]}) : {1'b0, mul_rsp.prod[63:20]};
        end
      spsc_pkg::ST_SUM: begin
        v_q    <= v_lim;
        av_q   <= av;
        code_q <= code;
        per_q  <= PER_TOP;
      end
      spsc_pkg::ST_PER_MUL:
        if (mul_rsp.done) den_q <= {5'd0, mul_rsp.prod[31:0]} << code_q;
      spsc_pkg::ST_PER_DIV:
        if (div_rsp.done) per_q <= per_new;
      spsc_pkg::ST_OUT:
        if (out_free) begin
          o_speed_q <= v_q;
          o_dir_q   <= ((v_q > 17'sd0) ? 1'b0 : 1'b1) ^ dir_inv_q;
          o_code_q  <= code_q;
          o_per_q   <= per_q;
        end
      default: ;
    endcase
  end

  assign out_o.valid           = ovalid_q;
  assign out_o.speed           = o_speed_q;
  assign out_o.direction_pin   = o_dir_q;
  assign out_o.ratio_code      = o_code_q;
  assign out_o.microstep_pins  = spsc_pkg::ms_pins(o_code_q);
  assign out_o.timer_period_us = o_per_q;

endmodule

### hdl/spsc_mul.sv
`timescale 1ns / 1ps
// shift-add multiplier, one multiplier bit per cycle
module spsc_mul (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spsc_pkg::mul_req_t  req_i,
  output spsc_pkg::mul_rsp_t  rsp_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [spsc_pkg::MUL_CNT_W-1:0]   cnt_q;
  logic [spsc_pkg::MUL_A_W-1:0]     a_q;
  logic [spsc_pkg::MUL_P_W-1:0]     p_q;
  logic [spsc_pkg::MUL_A_W:0]       sum;

  assign sum = {1'b0, p_q[spsc_pkg::MUL_P_W-1:spsc_pkg::MUL_B_W]}
             + (p_q[0] ? {1'b0, a_q} : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == spsc_pkg::MUL_CNT_W'(spsc_pkg::MUL_B_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      a_q <= req_i.a;
      p_q <= {{spsc_pkg::MUL_A_W{1'b0}}, req_i.b};
    end else if (busy_q) begin
      p_q <= {sum, p_q[spsc_pkg::MUL_B_W-1:1]};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.prod = p_q;

endmodule

### hdl/spsc_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle
module spsc_div (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  spsc_pkg::div_req_t  req_i,
  output spsc_pkg::div_rsp_t  rsp_o
);

  logic                             busy_q;
  logic                             done_q;
  logic [spsc_pkg::DIV_CNT_W-1:0]   cnt_q;
  logic [spsc_pkg::DIV_D_W-1:0]     d_q;
  logic [spsc_pkg::DIV_D_W-1:0]     rem_q;
  logic [spsc_pkg::DIV_N_W-1:0]     quo_q;
  logic [spsc_pkg::DIV_D_W:0]       r_sh;
  logic [spsc_pkg::DIV_D_W:0]       r_sub;
  logic                             ge;

  assign r_sh  = {rem_q, quo_q[spsc_pkg::DIV_N_W-1]};
  assign r_sub = r_sh - {1'b0, d_q};
  assign ge    = (r_sh >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == spsc_pkg::DIV_CNT_W'(spsc_pkg::DIV_N_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      d_q   <= req_i.d;
      rem_q <= '0;
      quo_q <= req_i.n;
    end else if (busy_q) begin
      rem_q <= ge ? r_sub[spsc_pkg::DIV_D_W-1:0] : r_sh[spsc_pkg::DIV_D_W-1:0];
      quo_q <= {quo_q[spsc_pkg::DIV_N_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = quo_q;

endmodule

### sim/stepper_pid_speed_controller_unit_test.sv
`timescale 1ns / 1ps
module stepper_pid_speed_controller_unit_test;

  // Result fields of one control tick.
  typedef struct packed {
    logic signed [16:0]                      speed;
    logic                                    dir;
    logic [2:0]                              code;
    logic [2:0]                              pins;
    logic [spsc_pkg::PERIOD_WIDTH-1:0]       period;
  } tick_res_t;

  // One row of the directed table. has_res marks rows typed in by hand.
  typedef struct {
    spsc_pkg::action_e act;
    longint            val;
    bit                has_res;
    tick_res_t         res;
  } row_t;

  localparam longint LIMIT_CYCLES = 3000000;
  localparam int     SETTLE = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [spsc_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [spsc_pkg::CFG_W-1:0] cfg_data_i = '0;

  spsc_in_if  in_if ();
  spsc_out_if out_if ();

  stepper_pid_speed_controller_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i), .in_i(in_if.sink), .out_o(out_if.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor copy of registers and controller state.
  longint unsigned kp, ki, kd, spr, dinv, dband, slew, vmax;
  longint tgt, meas, integ, prev_err, prev_speed;

  tick_res_t speed_queue[$];
  int  errors = 0;
  longint cycles = 0;
  int  src_idle_pct = 0, snk_idle_pct = 0;
  bit  hold_sink = 1'b0;

  function automatic longint sat(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint unsigned absv(longint v);
    return v < 0 ? -v : v;
  endfunction

  task automatic defaults();
    kp = 425984; ki = 32768; kd = 655; spr = 200; dinv = 0; dband = 128;
    slew = 8000; vmax = 57600;
    tgt = 0; meas = 0; integ = 0; prev_err = 0; prev_speed = 0;
  endtask

  // Advance the predictor by one transaction; returns 1 when a tick result is due.
  function automatic bit pid_predict(spsc_pkg::action_e act, longint val,
                                     output tick_res_t r);
    longint unsigned s_eff, dt, sm, hi, lo, rate, av, den, per, top, q;
    longint e, pt, it, dterm, de, v, lim;
    logic [2:0] code;
    r = '0;
    s_eff = (spr == 0) ? 1 : spr;
    if (act == spsc_pkg::ACT_TARGET) begin
      tgt = val; integ = 0;
      return 0;
    end
    if (act == spsc_pkg::ACT_POSITION) begin
      q = (absv(val) * 5760) / s_eff;
      meas = sat(val < 0 ? -longint'(q) : longint'(q), -64'sd2147483648, 64'sd2147483647);
      return 0;
    end
    if (act != spsc_pkg::ACT_TICK) return 0;
    dt = (val == 0) ? 1 : val;
    e = sat(tgt - meas, -64'sd2147483648, 64'sd2147483647);
    if (absv(e) < dband) e = 0;
    integ = sat(integ + e * longint'(dt), -64'sd140737488355328, 64'sd140737488355327);
    pt = longint'((kp * absv(e)) >> 20);
    if (e < 0) pt = -pt;
    sm = absv(integ);
    hi = ki * (sm >> 24);
    lo = ki * (sm & 64'hFFFFFF);
    it = longint'(((hi << 4) + (lo >> 20)) / 1000000);
    if (integ < 0) it = -it;
    de = e - prev_err;
    rate = (absv(de) * 1000000) / dt;
    if (rate > spsc_pkg::RATE_MAX) rate = spsc_pkg::RATE_MAX;
    dterm = longint'((kd * rate) >> 20);
    if (de < 0) dterm = -dterm;
    prev_err = e;
    v = pt + it + dterm;
    if (v > prev_speed + longint'(slew)) begin
      v = prev_speed + longint'(slew); integ = 0;
    end else if (v < prev_speed - longint'(slew)) begin
      v = prev_speed - longint'(slew); integ = 0;
    end
    lim = longint'(vmax);
    if (v > lim) begin
      v = lim; integ = 0;
    end else if (v < -lim) begin
      v = -lim; integ = 0;
    end
    prev_speed = v;
    av = absv(v);
    if (av < 720) code = 4;
    else if (av < 1440) code = 3;
    else if (av < 2880) code = 2;
    else if (av < 5760) code = 1;
    else code = 0;
    top = (64'd1 << spsc_pkg::PERIOD_WIDTH) - 1;
    if (av == 0) per = top;
    else begin
      den = av * s_eff * (64'd1 << code);
      per = 64'd5760000000 / den;
      if (per < 100) per = 100;
      if (per > top) per = top;
    end
    r.speed = v[16:0];
    r.dir = ((v > 0) ? 1'b0 : 1'b1) ^ dinv[0];
    r.code = code;
    r.pins = (code == 4) ? 3'b111 : (code == 3) ? 3'b011 : (code == 2) ? 3'b010 :
             (code == 1) ? 3'b001 : 3'b000;
    r.period = per[spsc_pkg::PERIOD_WIDTH-1:0];
    return 1;
  endfunction

  // Watchdog.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("[stepper_pid_speed_controller_unit] ERROR");
      $finish;
    end
  end

  // Result side: stall at random, compare each transaction with the oldest expectation.
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_if.ready <= 1'b0;
    else out_if.ready <= !hold_sink && ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk_i) begin
    tick_res_t got, want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      got = {out_if.speed, out_if.direction_pin, out_if.ratio_code,
             out_if.microstep_pins, out_if.timer_period_us};
      if (speed_queue.size() == 0) begin
        errors++;
        $display("%0t unexpected result %h", $time, got);
      end else begin
        want = speed_queue.pop_front();
        if (got.speed !== want.speed)
          $display("%0t speed exp %0d got %0d", $time, want.speed, got.speed);
        if (got.dir !== want.dir)
          $display("%0t dir exp %b got %b", $time, want.dir, got.dir);
        if (got.code !== want.code)
          $display("%0t ratio exp %0d got %0d", $time, want.code, got.code);
        if (got.pins !== want.pins)
          $display("%0t pins exp %b got %b", $time, want.pins, got.pins);
        if (got.period !== want.period)
          $display("%0t period exp %0d got %0d", $time, want.period, got.period);
        if (got !== want) errors++;
      end
    end
  end

  // Offers one transaction and predicts at acceptance; valid stays up on return
  // so that the next transaction can follow with no gap.
  task automatic send(spsc_pkg::action_e act, longint val, bit chk = 0,
                      tick_res_t ref_r = '0);
    tick_res_t r;
    bit due;
    while ($urandom_range(99) < src_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.action <= act;
    in_if.target_position <= (act == spsc_pkg::ACT_TARGET) ? val[23:0] : 24'($urandom);
    in_if.meas_steps <= (act == spsc_pkg::ACT_POSITION) ? val[23:0] : 24'($urandom);
    in_if.elapsed_us <= (act == spsc_pkg::ACT_TICK) ? val[19:0] : 20'($urandom);
    do @(posedge clk_i); while (!in_if.ready);
    due = pid_predict(act, val, r);
    if (due) begin
      if (chk && r !== ref_r) begin
        errors++;
        $display("%0t table row exp %h predictor %h", $time, ref_r, r);
      end
      speed_queue.push_back(chk ? ref_r : r);
    end
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (speed_queue.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
  endtask

  task automatic write_reg(spsc_pkg::cfg_idx_e idx, longint unsigned v);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= v[spsc_pkg::CFG_W-1:0];
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
    case (idx)
      spsc_pkg::CFG_GAIN_P: kp = v & 24'hFFFFFF;
      spsc_pkg::CFG_GAIN_I: ki = v & 24'hFFFFFF;
      spsc_pkg::CFG_GAIN_D: kd = v & 24'hFFFFFF;
      spsc_pkg::CFG_STEPS: spr = v & 16'hFFFF;
      spsc_pkg::CFG_DIR_INVERT: dinv = v & 1;
      spsc_pkg::CFG_DEADBAND: dband = v & 16'hFFFF;
      spsc_pkg::CFG_SLEW: slew = v & 16'hFFFF;
      default: vmax = v & 16'hFFFF;
    endcase
  endtask

  // Mostly well-formed sequences: occasional target/position loads, many ticks.
  task automatic random_item();
    int pick;
    longint v;
    pick = $urandom_range(99);
    if (pick < 8) begin
      v = $urandom_range(3) == 0 ? longint'($signed(24'($urandom)))
                                 : longint'($urandom_range(40000)) - 20000;
      send(spsc_pkg::ACT_TARGET, v);
    end else if (pick < 22) begin
      v = $urandom_range(3) == 0 ? longint'($signed(24'($urandom)))
                                 : longint'($urandom_range(4000)) - 2000;
      send(spsc_pkg::ACT_POSITION, v);
    end else if (pick < 25) begin
      send(spsc_pkg::action_e'(2'd3), 0);
    end else begin
      v = $urandom_range(4) == 0 ? longint'(20'($urandom)) : $urandom_range(1, 5000);
      send(spsc_pkg::ACT_TICK, v);
    end
  endtask

  task automatic random_cfg();
    write_reg(spsc_pkg::CFG_GAIN_P,
              $urandom_range(3) == 0 ? 24'($urandom) : $urandom_range(1000000));
    write_reg(spsc_pkg::CFG_GAIN_I,
              $urandom_range(3) == 0 ? 24'($urandom) : $urandom_range(100000));
    write_reg(spsc_pkg::CFG_GAIN_D,
              $urandom_range(3) == 0 ? 24'($urandom) : $urandom_range(5000));
    write_reg(spsc_pkg::CFG_STEPS,
              $urandom_range(3) == 0 ? 16'($urandom) : $urandom_range(400));
    write_reg(spsc_pkg::CFG_DIR_INVERT, $urandom_range(1));
    write_reg(spsc_pkg::CFG_DEADBAND,
              $urandom_range(3) == 0 ? 16'($urandom) : $urandom_range(300));
    write_reg(spsc_pkg::CFG_SLEW, 16'($urandom));
    write_reg(spsc_pkg::CFG_SPEED_LIMIT, 16'($urandom));
  endtask

  localparam tick_res_t ZERO_RES = '{speed: 17'sd0, dir: 1'b1, code: 3'd4, pins: 3'b111,
                                     period: 24'hFFFFFF};

  row_t table_rows[$];

  initial begin
    row_t rw;
    in_if.valid = 1'b0;
    in_if.action = spsc_pkg::ACT_TARGET;
    in_if.target_position = '0;
    in_if.meas_steps = '0;
    in_if.elapsed_us = '0;
    defaults();
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed table: a tick straight after reset gives zero speed, top period.
    table_rows = '{
      '{spsc_pkg::ACT_TICK, 1000, 1, ZERO_RES},
      '{spsc_pkg::ACT_TICK, 0, 1, ZERO_RES},
      '{spsc_pkg::action_e'(2'd3), 0, 0, '0},
      '{spsc_pkg::ACT_TARGET, 8388607, 0, '0},
      '{spsc_pkg::ACT_TICK, 1, 0, '0},
      '{spsc_pkg::ACT_TICK, 1048575, 0, '0},
      '{spsc_pkg::ACT_POSITION, 8388607, 0, '0},
      '{spsc_pkg::ACT_TICK, 100, 0, '0},
      '{spsc_pkg::ACT_TARGET, -8388608, 0, '0},
      '{spsc_pkg::ACT_POSITION, -8388608, 0, '0},
      '{spsc_pkg::ACT_TICK, 1000, 0, '0},
      '{spsc_pkg::ACT_TARGET, -8388608, 0, '0},
      '{spsc_pkg::ACT_POSITION, 8388607, 0, '0},
      '{spsc_pkg::ACT_TICK, 1, 0, '0},
      '{spsc_pkg::ACT_TICK, 1, 0, '0},
      '{spsc_pkg::ACT_TARGET, 100, 0, '0},
      '{spsc_pkg::ACT_POSITION, 0, 0, '0},
      '{spsc_pkg::ACT_TICK, 1000, 0, '0},
      '{spsc_pkg::ACT_TICK, 1000, 0, '0}
    };
    foreach (table_rows[k]) begin
      rw = table_rows[k];
      send(rw.act, rw.val, rw.has_res, rw.res);
    end
    drain();

    // Extreme settings: zero steps per rev, zero limits, full-scale gains.
    write_reg(spsc_pkg::CFG_STEPS, 0);
    write_reg(spsc_pkg::CFG_SLEW, 0);
    write_reg(spsc_pkg::CFG_DEADBAND, 0);
    write_reg(spsc_pkg::CFG_DIR_INVERT, 1);
    send(spsc_pkg::ACT_POSITION, 12345);
    send(spsc_pkg::ACT_TARGET, 5000);
    send(spsc_pkg::ACT_TICK, 10);
    drain();
    write_reg(spsc_pkg::CFG_SLEW, 65535);
    write_reg(spsc_pkg::CFG_SPEED_LIMIT, 65535);
    write_reg(spsc_pkg::CFG_GAIN_P, 24'hFFFFFF);
    write_reg(spsc_pkg::CFG_GAIN_I, 24'hFFFFFF);
    write_reg(spsc_pkg::CFG_GAIN_D, 24'hFFFFFF);
    write_reg(spsc_pkg::CFG_STEPS, 65535);
    send(spsc_pkg::ACT_TICK, 1);
    send(spsc_pkg::ACT_TARGET, -8388608);
    send(spsc_pkg::ACT_TICK, 1);
    send(spsc_pkg::ACT_TICK, 1048575);
    drain();
    write_reg(spsc_pkg::CFG_SPEED_LIMIT, 0);
    write_reg(spsc_pkg::CFG_DEADBAND, 65535);
    send(spsc_pkg::ACT_TICK, 7);
    drain();

    // Random phases with idling profiles; registers change between phases.
    for (int ph = 0; ph < 8; ph++) begin
      src_idle_pct = (ph % 3 == 0) ? 13 : (ph % 3 == 1) ? 45 : 0;
      snk_idle_pct = (ph % 3 == 0) ? 45 : (ph % 3 == 1) ? 13 : 0;
      if (ph == 7) begin
        write_reg(spsc_pkg::CFG_GAIN_P, 425984); write_reg(spsc_pkg::CFG_GAIN_I, 32768);
        write_reg(spsc_pkg::CFG_GAIN_D, 655); write_reg(spsc_pkg::CFG_STEPS, 200);
        write_reg(spsc_pkg::CFG_DIR_INVERT, 0); write_reg(spsc_pkg::CFG_DEADBAND, 128);
        write_reg(spsc_pkg::CFG_SLEW, 8000); write_reg(spsc_pkg::CFG_SPEED_LIMIT, 57600);
      end else random_cfg();
      for (int n = 0; n < 200; n++) begin
        // Long receiver hold-off while the sender keeps offering.
        if (ph == 2 && n == 50) begin
          fork
            begin
              hold_sink = 1'b1;
              repeat (3000) @(negedge clk_i);
              hold_sink = 1'b0;
            end
          join_none
        end
        // Sender pauses until every result is in.
        if (n == 120) begin
          in_if.valid <= 1'b0;
          while (speed_queue.size() != 0) @(negedge clk_i);
        end
        random_item();
      end
      drain();
    end

    if (errors == 0) begin
      $display("[stepper_pid_speed_controller_unit] OK");
    end else begin
      $display("[stepper_pid_speed_controller_unit] ERROR");
    end
    $finish;
  end

endmodule

### stepper_pid_speed_controller_unit.f
hdl/spsc_pkg.sv
hdl/spsc_in_if.sv
hdl/spsc_out_if.sv
hdl/spsc_mul.sv
hdl/spsc_div.sv
hdl/stepper_pid_speed_controller_unit.sv
sim/stepper_pid_speed_controller_unit_test.sv
